@@ hw/rtl/rgcp_pkg.sv @@
// Shared types and constants for the rectangle grid color pattern generator.
`default_nettype none

package rgcp_pkg;

    // Field widths
    localparam int COORD_W     = 12;
    localparam int GRID_W      = 8;
    localparam int COLOR_W     = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int BPP_W       = 6;
    localparam int CHAN_W      = 12;

    // Front-to-back queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_H_RES          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_V_RES          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_COLOR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_PIXEL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SIZES  = 3'd7;

    // Front sequencer states
    typedef enum logic [0:0] {
        ST_RUN,
        ST_DIV
    } t_front_state;

    // Live configuration
    typedef struct packed {
        logic [COORD_W-1:0] h_res;
        logic [COORD_W-1:0] v_res;
        logic [GRID_W-1:0]  rect_count;
        logic [COLOR_W-1:0] first_color;
        logic [7:0]         color_step;
        logic               direct_color;
        logic [BPP_W-1:0]   bits_per_pixel;
        logic [CHAN_W-1:0]  channel_sizes;
    } t_cfg;

    // Classified pixel handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               draw;
        logic               frame_end;
        logic [GRID_W-1:0]  col;
        logic [GRID_W-1:0]  row;
    } t_job;

endpackage

`default_nettype wire

@@ hw/rtl/rect_grid_color_pattern_generator_core.sv @@
// Top level: config registers, front end, queue and color back end.
//
// Usage
//   Input channel (i_in_valid / o_in_ready, i_restart): one word per pixel tick.
//   i_restart = 1 restarts the scan at pixel 0,0; 0 advances one pixel.
//   Output channel (o_out_valid / i_out_ready): one word per input word with
//   coordinates, draw flag, color (zero when not drawn) and frame-end flag.
//   Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data):
//   always ready; write only while no pixel is in flight.
// Timing
//   Ordinary pixels: one word per cycle while the queue has room; o_out_valid
//   rises after the queue write, two color stages and the output register.
//   Pixel 0,0: two 12-step restoring dividers recompute the rectangle size; the
//   front end holds that word until both finish and takes no new word meanwhile.
// Reset
//   Synchronous, active low; registers return to defaults, scan to 0,0,
//   rectangle sizes to zero until the first frame start.
// Stall
//   When the receiver holds off, the back end and the two-entry queue fill,
//   then o_in_ready drops; no word is lost.
`default_nettype none

module rect_grid_color_pattern_generator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rgcp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgcp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rgcp_pkg::COORD_W-1:0]    o_pixel_x,
    output logic [rgcp_pkg::COORD_W-1:0]    o_pixel_y,
    output logic                            o_draw,
    output logic [rgcp_pkg::COLOR_W-1:0]    o_pixel_color,
    output logic                            o_frame_end
);
    import rgcp_pkg::*;

    t_cfg r_cfg;
    t_job push_job, q_job;
    logic push, q_full, q_valid, q_ready;

    assign o_cfg_ready = 1'b1;

    // Config register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.h_res          <= 12'd1024;
            r_cfg.v_res          <= 12'd768;
            r_cfg.rect_count     <= 8'd4;
            r_cfg.first_color    <= '0;
            r_cfg.color_step     <= 8'd1;
            r_cfg.direct_color   <= 1'b0;
            r_cfg.bits_per_pixel <= 6'd8;
            r_cfg.channel_sizes  <= 12'h555;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_H_RES:          r_cfg.h_res          <= i_cfg_data[COORD_W-1:0];
                REG_V_RES:          r_cfg.v_res          <= i_cfg_data[COORD_W-1:0];
                REG_RECT_COUNT:     r_cfg.rect_count     <= i_cfg_data[GRID_W-1:0];
                REG_FIRST_COLOR:    r_cfg.first_color    <= i_cfg_data[COLOR_W-1:0];
                REG_COLOR_STEP:     r_cfg.color_step     <= i_cfg_data[7:0];
                REG_DIRECT_COLOR:   r_cfg.direct_color   <= i_cfg_data[0];
                REG_BITS_PER_PIXEL: r_cfg.bits_per_pixel <= i_cfg_data[BPP_W-1:0];
                REG_CHANNEL_SIZES:  r_cfg.channel_sizes  <= i_cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    rgcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_restart  (i_restart),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (q_full)
    );

    rgcp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    rgcp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (q_valid),
        .o_ready       (q_ready),
        .i_job         (q_job),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_draw        (o_draw),
        .o_pixel_color (o_pixel_color),
        .o_frame_end   (o_frame_end)
    );

endmodule

`default_nettype wire

@@ hw/rtl/rgcp_div.sv @@
// Restoring divider, one quotient bit per cycle, for the rectangle size.
`default_nettype none

module rgcp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rgcp_pkg::COORD_W-1:0] i_dividend,
    input  logic [rgcp_pkg::GRID_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [rgcp_pkg::COORD_W-1:0] o_quotient
);
    import rgcp_pkg::*;

    localparam int CNT_W = $clog2(COORD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(COORD_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [COORD_W-1:0] r_quo;
    logic [GRID_W-1:0]  r_rem;
    logic [GRID_W-1:0]  r_div;

    logic [GRID_W:0] trial;
    logic [GRID_W:0] diff;
    logic            ge;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_quo[COORD_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[GRID_W-1:0] : trial[GRID_W-1:0];
            r_quo <= {r_quo[COORD_W-2:0], ge};
        end
    end

    // A zero count gives zero-size rectangles
    assign o_done     = r_done;
    assign o_quotient = (r_div == '0) ? '0 : r_quo;

endmodule

`default_nettype wire

@@ hw/rtl/rgcp_front.sv @@
// Front end: raster scan, grid counters, rectangle size latch, draw classification.
`default_nettype none

module rgcp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rgcp_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_restart,
    output logic            o_push,
    output rgcp_pkg::t_job  o_job,
    input  logic            i_full
);
    import rgcp_pkg::*;

    t_front_state r_state, n_state;

    logic [COORD_W-1:0] r_scan_x, r_scan_y, r_off_x, r_off_y, r_rect_w, r_rect_h;
    logic [GRID_W-1:0]  r_col, r_row;

    logic [COORD_W-1:0] n_scan_x, n_scan_y, n_off_x, n_off_y;
    logic [GRID_W-1:0]  n_col, n_row;

    logic [COORD_W-1:0] cur_x, cur_y, cur_off_x, cur_off_y;
    logic [GRID_W-1:0]  cur_col, cur_row;
    logic [COORD_W-1:0] size_w, size_h, quo_w, quo_h;
    logic [COORD_W:0]   x_inc, y_inc, offx_inc, offy_inc;
    logic               clear, frame_start, accept, div_start;
    logic               div_done_w, div_done_h, div_done;
    logic               line_end, frame_end, drawn;

    // Size dividers, run side by side at frame start
    rgcp_div u_div_w (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_cfg.h_res),
        .i_divisor  (i_cfg.rect_count),
        .o_done     (div_done_w),
        .o_quotient (quo_w)
    );

    rgcp_div u_div_h (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_cfg.v_res),
        .i_divisor  (i_cfg.rect_count),
        .o_done     (div_done_h),
        .o_quotient (quo_h)
    );

    assign div_done = div_done_w & div_done_h;

    // Position after an optional restart
    always_comb begin
        clear     = (r_state == ST_RUN) && i_restart;
        cur_x     = clear ? '0 : r_scan_x;
        cur_y     = clear ? '0 : r_scan_y;
        cur_off_x = clear ? '0 : r_off_x;
        cur_off_y = clear ? '0 : r_off_y;
        cur_col   = clear ? '0 : r_col;
        cur_row   = clear ? '0 : r_row;
        frame_start = (cur_x == '0) && (cur_y == '0);
    end

    // Sizes: fresh quotients on the frame-start pixel, latched otherwise
    always_comb begin
        size_w = (r_state == ST_DIV) ? quo_w : r_rect_w;
        size_h = (r_state == ST_DIV) ? quo_h : r_rect_h;
        drawn  = (size_w != '0) && (size_h != '0) &&
                 (cur_col < i_cfg.rect_count) && (cur_row < i_cfg.rect_count);
    end

    // Line / frame end and next position
    always_comb begin
        x_inc     = {1'b0, cur_x} + 1'b1;
        y_inc     = {1'b0, cur_y} + 1'b1;
        offx_inc  = {1'b0, cur_off_x} + 1'b1;
        offy_inc  = {1'b0, cur_off_y} + 1'b1;
        line_end  = (x_inc >= {1'b0, i_cfg.h_res}) || x_inc[COORD_W];
        frame_end = line_end && ((y_inc >= {1'b0, i_cfg.v_res}) || y_inc[COORD_W]);

        n_scan_x = cur_x;
        n_scan_y = cur_y;
        n_off_x  = cur_off_x;
        n_off_y  = cur_off_y;
        n_col    = cur_col;
        n_row    = cur_row;
        if (line_end) begin
            n_scan_x = '0;
            n_off_x  = '0;
            n_col    = '0;
            if (frame_end) begin
                n_scan_y = '0;
                n_off_y  = '0;
                n_row    = '0;
            end else begin
                n_scan_y = y_inc[COORD_W-1:0];
                if (size_h == '0) begin
                    n_off_y = '0;
                end else if (offy_inc >= {1'b0, size_h}) begin
                    n_off_y = '0;
                    if (cur_row != '1) n_row = cur_row + 1'b1;
                end else begin
                    n_off_y = offy_inc[COORD_W-1:0];
                end
            end
        end else begin
            n_scan_x = x_inc[COORD_W-1:0];
            if (size_w == '0) begin
                n_off_x = '0;
            end else if (offx_inc >= {1'b0, size_w}) begin
                n_off_x = '0;
                if (cur_col != '1) n_col = cur_col + 1'b1;
            end else begin
                n_off_x = offx_inc[COORD_W-1:0];
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN:  if (div_start) n_state = ST_DIV;
            ST_DIV:  if (div_done) n_state = ST_RUN;
            default: n_state = ST_RUN;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready = (r_state == ST_RUN) && !i_full;
        accept     = i_in_valid && o_in_ready;
        div_start  = accept && frame_start;
        o_push     = (accept && !frame_start) || ((r_state == ST_DIV) && div_done);
    end

    assign o_job = '{x: cur_x, y: cur_y, draw: drawn, frame_end: frame_end,
                     col: cur_col, row: cur_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RUN;
            r_scan_x <= '0;
            r_scan_y <= '0;
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_rect_w <= '0;
            r_rect_h <= '0;
        end else begin
            r_state <= n_state;
            if (div_start) begin
                // hold the restarted position while sizes are worked out
                r_scan_x <= cur_x;
                r_scan_y <= cur_y;
                r_off_x  <= cur_off_x;
                r_off_y  <= cur_off_y;
                r_col    <= cur_col;
                r_row    <= cur_row;
            end else if (o_push) begin
                r_scan_x <= n_scan_x;
                r_scan_y <= n_scan_y;
                r_off_x  <= n_off_x;
                r_off_y  <= n_off_y;
                r_col    <= n_col;
                r_row    <= n_row;
                if (r_state == ST_DIV) begin
                    r_rect_w <= quo_w;
                    r_rect_h <= quo_h;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rgcp_fifo.sv @@
// Two-entry queue of classified pixels between front and back.
`default_nettype none

module rgcp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rgcp_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_ready,
    output rgcp_pkg::t_job o_job
);
    import rgcp_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)    r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

endmodule

`default_nettype wire

@@ hw/rtl/rgcp_back.sv @@
// Back end: three-stage color pipeline ending in the output register.
`default_nettype none

module rgcp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rgcp_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  rgcp_pkg::t_job               i_job,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rgcp_pkg::COORD_W-1:0] o_pixel_x,
    output logic [rgcp_pkg::COORD_W-1:0] o_pixel_y,
    output logic                         o_draw,
    output logic [rgcp_pkg::COLOR_W-1:0] o_pixel_color,
    output logic                         o_frame_end
);
    import rgcp_pkg::*;

    localparam int IDX_W  = 2 * GRID_W;
    localparam int PROD_W = IDX_W + 8;

    // Channel size, capped at a byte
    function automatic logic [3:0] chan_size(input logic [3:0] s);
        return (s > 4'd8) ? 4'd8 : s;
    endfunction

    function automatic logic [7:0] chan_mask(input logic [3:0] s);
        logic [8:0] m;
        m = (9'd1 << s) - 9'd1;
        return m[7:0];
    endfunction

    // Indexed wrap; depth of 32 or more keeps every bit
    function automatic logic [COLOR_W-1:0] bpp_mask(input logic [BPP_W-1:0] b);
        logic [COLOR_W:0] m;
        m = ({{COLOR_W{1'b0}}, 1'b1} << b) - 1'b1;
        return (b >= BPP_W'(COLOR_W)) ? '1 : m[COLOR_W-1:0];
    endfunction

    logic en1, en2, en3;

    logic               r1_valid, r2_valid, r3_valid;
    t_job               r1_job, r2_job;
    logic [IDX_W-1:0]   r1_rowrc;
    logic [7:0]         r1_colstep, r1_rowstep, r1_sumstep;
    logic [PROD_W-1:0]  r2_prod;
    logic [7:0]         r2_r, r2_g, r2_b;

    logic [IDX_W-1:0]   n1_rowrc;
    logic [7:0]         n1_colstep, n1_rowstep, n1_sumstep;
    logic [IDX_W-1:0]   idx;
    logic [PROD_W-1:0]  n2_prod;
    logic [7:0]         n2_r, n2_g, n2_b;
    logic [3:0]         rs, gs, bs;
    logic [4:0]         rg_shift;
    logic [COLOR_W-1:0] idx_color, rgb_color, n3_color;

    // Stall chain: a stage moves when the one after it frees up
    assign en3     = !r3_valid || i_out_ready;
    assign en2     = !r2_valid || en3;
    assign en1     = !r1_valid || en2;
    assign o_ready = en1;

    // Stage 1: grid products
    always_comb begin
        n1_rowrc   = IDX_W'(i_job.row) * IDX_W'(i_cfg.rect_count);
        n1_colstep = 8'(i_job.col * i_cfg.color_step);
        n1_rowstep = 8'(i_job.row * i_cfg.color_step);
        n1_sumstep = 8'((i_job.col + i_job.row) * i_cfg.color_step);
    end

    // Stage 2: index times step, channel wrap
    always_comb begin
        rs      = chan_size(i_cfg.channel_sizes[11:8]);
        gs      = chan_size(i_cfg.channel_sizes[7:4]);
        bs      = chan_size(i_cfg.channel_sizes[3:0]);
        idx     = r1_rowrc + IDX_W'(r1_job.col);
        n2_prod = PROD_W'(idx) * PROD_W'(i_cfg.color_step);
        n2_r    = (i_cfg.first_color[23:16] + r1_colstep) & chan_mask(rs);
        n2_g    = (i_cfg.first_color[15:8] + r1_rowstep) & chan_mask(gs);
        n2_b    = (i_cfg.first_color[7:0] + r1_sumstep) & chan_mask(bs);
    end

    // Stage 3: final add and pack
    always_comb begin
        rg_shift  = {1'b0, gs} + {1'b0, bs};
        idx_color = (i_cfg.first_color + COLOR_W'(r2_prod)) &
                    bpp_mask(i_cfg.bits_per_pixel);
        rgb_color = COLOR_W'(r2_b) | (COLOR_W'(r2_g) << bs) |
                    (COLOR_W'(r2_r) << rg_shift);
        if (!r2_job.draw)
            n3_color = '0;
        else if (i_cfg.direct_color)
            n3_color = rgb_color;
        else
            n3_color = idx_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_job     <= i_job;
            r1_rowrc   <= n1_rowrc;
            r1_colstep <= n1_colstep;
            r1_rowstep <= n1_rowstep;
            r1_sumstep <= n1_sumstep;
        end
        if (en2) begin
            r2_job  <= r1_job;
            r2_prod <= n2_prod;
            r2_r    <= n2_r;
            r2_g    <= n2_g;
            r2_b    <= n2_b;
        end
        if (en3) begin
            o_pixel_x     <= r2_job.x;
            o_pixel_y     <= r2_job.y;
            o_draw        <= r2_job.draw;
            o_frame_end   <= r2_job.frame_end;
            o_pixel_color <= n3_color;
        end
    end

    assign o_out_valid = r3_valid;

endmodule

`default_nettype wire

@@ hw/rtl/rgcp_checker.sv @@
// Port-level checks for the pattern generator, bound to the top level.
`default_nettype none

module rgcp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [rgcp_pkg::COORD_W-1:0] o_pixel_x,
    input logic [rgcp_pkg::COORD_W-1:0] o_pixel_y,
    input logic                         o_draw,
    input logic [rgcp_pkg::COLOR_W-1:0] o_pixel_color
);
    import rgcp_pkg::*;

    // Stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_pixel_color) && $stable(o_pixel_x))
        else $error("output word changed while stalled");

    // Pixels outside the grid carry no color
    a_blank_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_draw |-> o_pixel_color == '0)
        else $error("undrawn pixel has nonzero color");

    // Resolution tops out one below the coordinate range
    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pixel_x != '1)
        else $error("column past last coordinate");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pixel_y != '1)
        else $error("line past last coordinate");

endmodule

bind rect_grid_color_pattern_generator_core rgcp_checker u_rgcp_checker (.*);

`default_nettype wire
